@@ rtl/core/mbe_pkg.sv @@
// Shared types, constants and helpers for the escape-time engine
package mbe_pkg;

  localparam int unsigned ImageSize = 8192;
  localparam int unsigned FracBits  = 28;
  localparam int unsigned NumCells  = 4;

  localparam logic signed [31:0] XOriginReset = -32'sd563714458;
  localparam logic signed [31:0] YOriginReset = -32'sd348966093;
  localparam logic [28:0]        XStepReset   = 29'd101581;
  localparam logic [28:0]        YStepReset   = 29'd85197;
  localparam logic [15:0]        LimitReset   = 16'd1000;

  typedef enum logic [2:0] {
    REG_X_ORIGIN = 3'd0,
    REG_Y_ORIGIN = 3'd1,
    REG_X_STEP   = 3'd2,
    REG_Y_STEP   = 3'd3,
    REG_LIMIT    = 3'd4
  } reg_index_t;

  // One token circulating through the ring of cells
  typedef struct packed {
    logic               busy;
    logic               done;
    logic               last;
    logic [15:0]        count;
    logic signed [31:0] zr;
    logic signed [31:0] zi;
    logic signed [31:0] cr;
    logic signed [31:0] ci;
  } mbe_token_t;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -35'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

@@ rtl/core/mandelbrot_escape_time_top.sv @@
// Top level: pixel mapping, ring of iteration cells, output register
//
//  channel  | dir | handshake          | payload
//  s_axis   | in  | tvalid/tready      | tdata row,column; tlast strip_end
//  m_axis   | out | tvalid/tready      | tdata count; tlast last_of_strip
//  cfg      | in  | cfg_we             | cfg_index, cfg_data
//
// One pixel at a time. Mapping runs in the MAP and LOAD states; each iteration
// passes the stage and output registers of one cell. The token walks the ring
// of NUM_CELLS cells until it is done at the ring end, so the result is ready
// after P = NUM_CELLS*ceil((count+1)/NUM_CELLS) <= count + NUM_CELLS passes.
// The next pixel is taken in the cycle after the result transaction.
// Reset restores the register defaults and empties the ring. A stalled
// result holds in the output register; a new pixel is taken once it is free.
module mandelbrot_escape_time_top
  import mbe_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBits,
  parameter int unsigned NUM_CELLS = NumCells
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // row[12:0], column[25:13], zeros
  input  logic        s_axis_tlast,  // strip_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // count[15:0]
  output logic        m_axis_tlast,  // last_of_strip
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [1:0] {IDLE, MAP, LOAD, RUN} state_t;

  state_t              state;
  logic signed [31:0]  x_origin, y_origin;
  logic [28:0]         x_step, y_step;
  logic [15:0]         limit;
  logic [12:0]         row, column;
  logic                last;
  logic [41:0]         px, py;
  mbe_token_t          ring [NUM_CELLS+1];
  mbe_token_t          inject;

  assign s_axis_tready = (state == IDLE) && !m_axis_tvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_origin <= XOriginReset;
      y_origin <= YOriginReset;
      x_step   <= XStepReset;
      y_step   <= YStepReset;
      limit    <= LimitReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_X_ORIGIN: x_origin <= cfg_data;
        REG_Y_ORIGIN: y_origin <= cfg_data;
        REG_X_STEP:   x_step   <= cfg_data[28:0];
        REG_Y_STEP:   y_step   <= cfg_data[28:0];
        REG_LIMIT:    limit    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: if (s_axis_tvalid && s_axis_tready) begin
          row    <= s_axis_tdata[12:0];
          column <= s_axis_tdata[25:13];
          last   <= s_axis_tlast;
          state  <= MAP;
        end
        MAP: begin
          px    <= 42'(column) * 42'(x_step);
          py    <= 42'(row) * 42'(y_step);
          state <= LOAD;
        end
        LOAD: begin
          state <= RUN;
        end
        RUN: begin
          if (ring[NUM_CELLS].busy && ring[NUM_CELLS].done) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= ring[NUM_CELLS].count;
            m_axis_tlast  <= ring[NUM_CELLS].last;
            state         <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  always_comb begin
    inject       = ring[NUM_CELLS];
    inject.busy  = 1'b0;
    if (state == LOAD) begin
      inject.busy  = 1'b1;
      inject.done  = 1'b0;
      inject.last  = last;
      inject.count = '0;
      inject.zr    = '0;
      inject.zi    = '0;
      inject.cr    = (|px[41:33]) ? 32'sh7FFF_FFFF
                   : sat32(35'(x_origin) + 35'($signed({2'b00, px[32:0]})));
      inject.ci    = (|py[41:33]) ? 32'sh7FFF_FFFF
                   : sat32(35'(y_origin) + 35'($signed({2'b00, py[32:0]})));
    end else if (state == RUN && !ring[NUM_CELLS].done) begin
      inject.busy = ring[NUM_CELLS].busy;
    end
    ring[0] = inject;
  end

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    mbe_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .limit  (limit),
      .tok_in (ring[g]),
      .tok_out(ring[g+1])
    );
  end

endmodule

@@ rtl/core/mbe_cell.sv @@
// One ring cell: squares the held z, then tests escape and updates z on the next cycle
module mbe_cell
  import mbe_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] limit,
  input  mbe_token_t  tok_in,
  output mbe_token_t  tok_out
);

  mbe_token_t        stage;
  logic signed [63:0] sq_r;
  logic signed [63:0] sq_i;
  logic signed [63:0] prod;

  logic [63:0]        sx;
  logic [63:0]        sy;
  logic [64:0]        mag;
  logic signed [63:0] pf;
  logic               escape;
  logic               stop;
  mbe_token_t         tok_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.busy <= 1'b0;
      tok_out.busy <= 1'b0;
    end else begin
      stage.busy   <= tok_in.busy;
      tok_out.busy <= tok_next.busy;
    end
    stage.done  <= tok_in.done;
    stage.last  <= tok_in.last;
    stage.count <= tok_in.count;
    stage.zr    <= tok_in.zr;
    stage.zi    <= tok_in.zi;
    stage.cr    <= tok_in.cr;
    stage.ci    <= tok_in.ci;
    sq_r <= tok_in.zr * tok_in.zr;
    sq_i <= tok_in.zi * tok_in.zi;
    prod <= tok_in.zr * tok_in.zi;
    tok_out.done  <= tok_next.done;
    tok_out.last  <= tok_next.last;
    tok_out.count <= tok_next.count;
    tok_out.zr    <= tok_next.zr;
    tok_out.zi    <= tok_next.zi;
    tok_out.cr    <= tok_next.cr;
    tok_out.ci    <= tok_next.ci;
  end

  always_comb begin
    sx     = 64'(sq_r) >> FRAC_BITS;
    sy     = 64'(sq_i) >> FRAC_BITS;
    mag    = {1'b0, sx} + {1'b0, sy};
    pf     = prod >>> (FRAC_BITS - 1);
    escape = mag >= (65'd1 << (FRAC_BITS + 2));
    stop   = stage.done || (stage.count >= limit) || escape;
    tok_next = stage;
    if (stage.busy && !stop) begin
      tok_next.count = stage.count + 16'd1;
      tok_next.zr = sat32(35'($signed({1'b0, sx})) - 35'($signed({1'b0, sy}))
                          + 35'(stage.cr));
      tok_next.zi = sat32(35'(pf) + 35'(stage.ci));
    end else if (stage.busy) begin
      tok_next.done = 1'b1;
    end
  end

endmodule
